// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

    // heap geometry
    localparam int CAPACITY = 1024;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = ADDR_W + 2;    // holds 2*pos+2
    localparam int ENTRY_W  = 11;
    localparam int STAT_W   = 2;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [ENTRY_W-1:0]       entry_t;
    typedef logic [STAT_W-1:0]        stat_code_t;

    // command field
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // status codes
    localparam stat_code_t ST_OK    = 2'd0;
    localparam stat_code_t ST_EMPTY = 2'd1;
    localparam stat_code_t ST_FULL  = 2'd2;

    localparam data_t EMPTY_POP_VAL = -1;

    typedef struct packed {
        logic  cmd;
        data_t value;
    } in_word_t;

    typedef struct packed {
        data_t      popped_value;
        data_t      top_value;
        entry_t     entry_count;
        stat_code_t status;
    } out_word_t;

    // datapath operations
    localparam int OP_W = 4;
    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_NONE     = 4'd0;
    localparam op_t OP_LOAD     = 4'd1;
    localparam op_t OP_INS      = 4'd2;
    localparam op_t OP_SWIM     = 4'd3;
    localparam op_t OP_SWIM_CMP = 4'd4;
    localparam op_t OP_POP      = 4'd5;
    localparam op_t OP_POP_LAST = 4'd6;
    localparam op_t OP_SNK_L    = 4'd7;
    localparam op_t OP_SNK_R    = 4'd8;
    localparam op_t OP_SNK_CMP  = 4'd9;
    localparam op_t OP_EMIT     = 4'd10;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic full;       // count == CAPACITY
        logic empty;      // count == 0
        logic last_one;   // count == 1
        logic pos_zero;   // hole at root
        logic swim_up;    // held value beats parent
        logic lc_in;      // left child inside heap
        logic sink_move;  // a child beats the held value
        logic out_free;   // output register can take a word
    } dp_stat_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mhpq_dp.sv =====
module mhpq_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mhpq_pkg::dp_cmd_t   cmd,
    output mhpq_pkg::dp_stat_t  stat,
    input  mhpq_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::out_word_t out_word
);

    mhpq_pkg::data_t        cur_reg, cur_next;
    mhpq_pkg::addr_t        pos_reg, pos_next;
    mhpq_pkg::cnt_t         cnt_reg, cnt_next;
    mhpq_pkg::data_t        root_reg, root_next;
    mhpq_pkg::data_t        lval_reg, lval_next;
    logic                   rvalid_reg, rvalid_next;
    mhpq_pkg::data_t        popped_reg, popped_next;
    mhpq_pkg::stat_code_t   status_reg, status_next;
    mhpq_pkg::out_word_t    out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   wr_en, rd_en;
    mhpq_pkg::addr_t        wr_addr, rd_addr;
    mhpq_pkg::data_t        wr_data;
    logic [mhpq_pkg::DATA_W-1:0] rd_raw;
    mhpq_pkg::data_t        rd_val;

    mhpq_pkg::addr_t        parent;
    mhpq_pkg::idx_t         lc, rc, n_ext;
    logic                   rc_in;
    logic                   l_gt, r_gt;
    mhpq_pkg::data_t        bval, mval;
    mhpq_pkg::addr_t        child;

    mhpq_ram #(
        .WIDTH(mhpq_pkg::DATA_W),
        .DEPTH(mhpq_pkg::CAPACITY)
    ) u_heap_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_raw)
    );

    assign rd_val = mhpq_pkg::data_t'(rd_raw);

    // heap index arithmetic
    assign parent = mhpq_pkg::addr_t'((pos_reg - 1'b1) >> 1);
    assign lc     = mhpq_pkg::idx_t'({pos_reg, 1'b1});
    assign rc     = mhpq_pkg::idx_t'(lc + 1'b1);
    assign n_ext  = mhpq_pkg::idx_t'(cnt_reg);
    assign rc_in  = (rc < n_ext);

    // larger-child pick; left wins ties
    assign l_gt  = (lval_reg > cur_reg);
    assign bval  = l_gt ? lval_reg : cur_reg;
    assign r_gt  = rvalid_reg && (rd_val > bval);
    assign mval  = r_gt ? rd_val : lval_reg;
    assign child = r_gt ? mhpq_pkg::addr_t'(rc) : mhpq_pkg::addr_t'(lc);

    always_comb
    begin
        stat.full      = (cnt_reg == mhpq_pkg::cnt_t'(mhpq_pkg::CAPACITY));
        stat.empty     = (cnt_reg == '0);
        stat.last_one  = (cnt_reg == mhpq_pkg::cnt_t'(1));
        stat.pos_zero  = (pos_reg == '0);
        stat.swim_up   = (cur_reg > rd_val);
        stat.lc_in     = (lc < n_ext);
        stat.sink_move = l_gt || r_gt;
        stat.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        lval_next      = lval_reg;
        rvalid_next    = rvalid_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = cur_reg;
        rd_en          = 1'b0;
        rd_addr        = parent;

        case (cmd.op)
            mhpq_pkg::OP_LOAD:
            begin
                cur_next = in_word.value;
            end
            mhpq_pkg::OP_INS:
            begin
                popped_next = '0;
                if (stat.full)
                begin
                    status_next = mhpq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = mhpq_pkg::ST_OK;
                    pos_next    = mhpq_pkg::addr_t'(cnt_reg);
                    cnt_next    = mhpq_pkg::cnt_t'(cnt_reg + 1'b1);
                end
            end
            mhpq_pkg::OP_SWIM:
            begin
                if (stat.pos_zero)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent;
                end
            end
            mhpq_pkg::OP_SWIM_CMP:
            begin
                wr_en = 1'b1;
                if (stat.swim_up)
                begin
                    wr_data  = rd_val;
                    pos_next = parent;
                end
            end
            mhpq_pkg::OP_POP:
            begin
                if (stat.empty)
                begin
                    popped_next = mhpq_pkg::EMPTY_POP_VAL;
                    status_next = mhpq_pkg::ST_EMPTY;
                end
                else
                begin
                    popped_next = root_reg;
                    status_next = mhpq_pkg::ST_OK;
                    cnt_next    = mhpq_pkg::cnt_t'(cnt_reg - 1'b1);
                    rd_en       = 1'b1;
                    rd_addr     = mhpq_pkg::addr_t'(cnt_reg - 1'b1);
                end
            end
            mhpq_pkg::OP_POP_LAST:
            begin
                cur_next = rd_val;
                pos_next = '0;
            end
            mhpq_pkg::OP_SNK_L:
            begin
                if (stat.lc_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mhpq_pkg::addr_t'(lc);
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            mhpq_pkg::OP_SNK_R:
            begin
                lval_next   = rd_val;
                rvalid_next = rc_in;
                if (rc_in)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mhpq_pkg::addr_t'(rc);
                end
            end
            mhpq_pkg::OP_SNK_CMP:
            begin
                wr_en = 1'b1;
                if (stat.sink_move)
                begin
                    wr_data  = mval;
                    pos_next = child;
                end
            end
            mhpq_pkg::OP_EMIT:
            begin
                out_next.popped_value = popped_reg;
                out_next.top_value    = stat.empty ? mhpq_pkg::data_t'(0) : root_reg;
                out_next.entry_count  = mhpq_pkg::entry_t'(cnt_reg);
                out_next.status       = status_reg;
                out_valid_next        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // root copy follows every write to slot zero
    assign root_next = (wr_en && wr_addr == '0) ? wr_data : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        pos_reg    <= pos_next;
        root_reg   <= root_next;
        lval_reg   <= lval_next;
        rvalid_reg <= rvalid_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== rtl/mhpq_ctrl.sv =====
module mhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    output mhpq_pkg::dp_cmd_t  cmd,
    input  mhpq_pkg::dp_stat_t stat
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS      = 4'd1;
    localparam logic [3:0] S_SWIM     = 4'd2;
    localparam logic [3:0] S_SWIM_CMP = 4'd3;
    localparam logic [3:0] S_POP      = 4'd4;
    localparam logic [3:0] S_POP_LAST = 4'd5;
    localparam logic [3:0] S_SNK_L    = 4'd6;
    localparam logic [3:0] S_SNK_R    = 4'd7;
    localparam logic [3:0] S_SNK_CMP  = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = mhpq_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = mhpq_pkg::OP_LOAD;
                    state_next = (in_cmd == mhpq_pkg::CMD_POP) ? S_POP : S_INS;
                end
            end
            S_INS:
            begin
                cmd.op     = mhpq_pkg::OP_INS;
                state_next = stat.full ? S_EMIT : S_SWIM;
            end
            S_SWIM:
            begin
                cmd.op     = mhpq_pkg::OP_SWIM;
                state_next = stat.pos_zero ? S_EMIT : S_SWIM_CMP;
            end
            S_SWIM_CMP:
            begin
                cmd.op     = mhpq_pkg::OP_SWIM_CMP;
                state_next = stat.swim_up ? S_SWIM : S_EMIT;
            end
            S_POP:
            begin
                cmd.op     = mhpq_pkg::OP_POP;
                state_next = (stat.empty || stat.last_one) ? S_EMIT : S_POP_LAST;
            end
            S_POP_LAST:
            begin
                cmd.op     = mhpq_pkg::OP_POP_LAST;
                state_next = S_SNK_L;
            end
            S_SNK_L:
            begin
                cmd.op     = mhpq_pkg::OP_SNK_L;
                state_next = stat.lc_in ? S_SNK_R : S_EMIT;
            end
            S_SNK_R:
            begin
                cmd.op     = mhpq_pkg::OP_SNK_R;
                state_next = S_SNK_CMP;
            end
            S_SNK_CMP:
            begin
                cmd.op     = mhpq_pkg::OP_SNK_CMP;
                state_next = stat.sink_move ? S_SNK_L : S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = mhpq_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// channel | valid    | ready     | word                    | fields
// --------+----------+-----------+-------------------------+------------------------------------
// in      | in_valid | in_ready  | in_word  (in_word_t)    | cmd, value
// out     | out_valid| out_ready | out_word (out_word_t)   | popped_value, top_value,
//         |          |           |                         | entry_count, status
//
// Insert: load, reserve a slot, then a parent read and a compare per level climbed, then emit.
// Pop: load, take the root, move the last item to the root, then a left read, a right read and
// a compare per level sunk, then emit. Full insert, empty pop and pop of the last item go
// straight to emit after the insert or pop step. One RAM read per cycle sets the pace.
// Reset clears the count and output valid; the heap RAM needs no clearing.
// A finished word sits in the output register; the next input word is taken while it
// waits, and a result is held back only until that register frees up.

module max_heap_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mhpq_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::out_word_t out_word
);

    mhpq_pkg::dp_cmd_t  dp_cmd;
    mhpq_pkg::dp_stat_t dp_stat;

    // sequencer: walks one heap level per swim round (read, compare) or sink round (left, right, compare)
    mhpq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_cmd  (in_word.cmd),
        .in_ready(in_ready),
        .cmd     (dp_cmd),
        .stat    (dp_stat)
    );

    // heap RAM, count, hole position, root copy and output register
    mhpq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word)
    );

    // one word in flight: no new word taken right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // count reported never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.entry_count <= mhpq_pkg::entry_t'(mhpq_pkg::CAPACITY)))
        else $error("entry count above capacity");

    // empty pop reports an empty heap
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status == mhpq_pkg::ST_EMPTY) |->
        (out_word.entry_count == '0 && out_word.top_value == '0 &&
         out_word.popped_value == mhpq_pkg::EMPTY_POP_VAL))
        else $error("empty pop result inconsistent");

    // full insert reports a full heap
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status == mhpq_pkg::ST_FULL) |->
        (out_word.entry_count == mhpq_pkg::entry_t'(mhpq_pkg::CAPACITY) &&
         out_word.popped_value == '0))
        else $error("full insert result inconsistent");

endmodule
